// ===== rtl/seven_segment_serial_display_driver_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment serial display driver.
// Each macro checks a property on the rising edge of clk while arst_n is high.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SERIAL_DISPLAY_DRIVER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssd assertion failed");

`endif

// ===== rtl/ssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, command bytes and the digit glyph table of the display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// Sequencer steps of one frame on the two-wire link.
	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_START   = 4'd1,
		ST_BITLOW  = 4'd2,
		ST_BITDATA = 4'd3,
		ST_BITHIGH = 4'd4,
		ST_ACK0    = 4'd5,
		ST_ACK1    = 4'd6,
		ST_ACK2    = 4'd7,
		ST_ACK3    = 4'd8,
		ST_STOP0   = 4'd9,
		ST_STOP1   = 4'd10,
		ST_STOP2   = 4'd11
	} ssd_step_t;

	// Kinds of input item.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SHOW = 1'b1;

	// Frame numbers inside one digit.
	localparam logic [1:0] FRAME_DATA = 2'd0;
	localparam logic [1:0] FRAME_ADDR = 2'd1;
	localparam logic [1:0] FRAME_SEG  = 2'd2;
	localparam logic [1:0] FRAME_CTRL = 2'd3;
	localparam logic [1:0] LAST_DIGIT = 2'd3;

	// Command bytes.
	localparam logic [7:0] CMD_DATA = 8'h44;
	localparam logic [7:0] CMD_ADDR = 8'hC0;
	localparam logic [7:0] CMD_CTRL = 8'h80;

	// Number range and the reciprocal used for division by ten.
	localparam int         NUM_W       = 14;
	localparam logic [13:0] NUM_MOD    = 14'd10000;
	localparam logic [16:0] RECIP_TEN  = 17'd52429;
	localparam int         RECIP_SHIFT = 19;

	// One input item.
	typedef struct packed {
		logic              line_in;
		logic              dot;
		logic [NUM_W-1:0]  number;
		logic              op;
	} ssd_item_t;

	// One result item.
	typedef struct packed {
		logic done;
		logic busy;
		logic data_pull_low;
		logic clock_line_high;
	} ssd_result_t;

	// Segment pattern of a decimal digit; bit 7 is left for the dot.
	function automatic logic [7:0] glyph(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0: seg = 8'h3F;
			4'd1: seg = 8'h06;
			4'd2: seg = 8'h5B;
			4'd3: seg = 8'h4F;
			4'd4: seg = 8'h66;
			4'd5: seg = 8'h6D;
			4'd6: seg = 8'h7D;
			4'd7: seg = 8'h07;
			4'd8: seg = 8'h7F;
			4'd9: seg = 8'h6F;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

// ===== rtl/ssd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_seq
// Frame sequencer: keeps the link state and produces the line levels for
// each item that it is given. The digits are peeled off the stored number
// one at a time, ones first, as each segment byte is loaded.
// ----------------------------------------------------------------------------
module ssd_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  ssd_pkg::ssd_item_t item,
	input  logic [3:0]         brightness,
	output ssd_pkg::ssd_result_t result
);
	import ssd_pkg::*;

	ssd_step_t        step_q, step_d;
	logic [7:0]       shift_q, shift_d;
	logic [3:0]       bitcnt_q, bitcnt_d;
	logic [1:0]       frame_q, frame_d;
	logic [1:0]       digit_q, digit_d;
	logic             clk_q, clk_d;
	logic             dlow_q, dlow_d;
	logic [NUM_W-1:0] rem_q, rem_d;
	logic             dot_q, dot_d;
	logic             done_d;
	logic             idle;
	logic             last_frame;
	logic [3:0]       bitcnt_inc;
	logic [NUM_W-1:0] num_mod;
	logic [30:0]      recip_prod;
	logic [NUM_W-1:0] quot;
	logic [NUM_W-1:0] quot_x10;
	logic [3:0]       digit_val;

	assign idle       = (step_q == ST_IDLE) || (step_q > ST_STOP2);
	assign last_frame = (frame_q == FRAME_CTRL) && (digit_q == LAST_DIGIT);
	assign bitcnt_inc = bitcnt_q + 4'd1;

	// Fold a number above the four-digit range back into it.
	assign num_mod = (item.number >= NUM_MOD) ? (item.number - NUM_MOD) : item.number;

	// Lowest decimal digit of the stored number and the rest of it.
	// The stored number stays below 10000, so the quotient fits in 12 bits.
	assign recip_prod = {17'd0, rem_q} * {14'd0, RECIP_TEN};
	assign quot       = {2'd0, recip_prod[30:RECIP_SHIFT]};
	assign quot_x10   = (quot << 3) + (quot << 1);
	assign digit_val  = 4'(rem_q - quot_x10);

	// Next step.
	always_comb begin
		step_d = step_q;
		if (step_en) begin
			if (item.op == OP_SHOW) begin
				if (idle) begin
					step_d = ST_START;
				end
			end else begin
				case (step_q)
					ST_IDLE:    step_d = ST_IDLE;
					ST_START:   step_d = ST_BITLOW;
					ST_BITLOW:  step_d = ST_BITDATA;
					ST_BITDATA: step_d = ST_BITHIGH;
					ST_BITHIGH: step_d = bitcnt_inc[3] ? ST_ACK0 : ST_BITLOW;
					ST_ACK0:    step_d = ST_ACK1;
					ST_ACK1:    step_d = ST_ACK2;
					ST_ACK2:    step_d = ST_ACK3;
					ST_ACK3:    step_d = (frame_q == FRAME_ADDR) ? ST_BITLOW : ST_STOP0;
					ST_STOP0:   step_d = ST_STOP1;
					ST_STOP1:   step_d = ST_STOP2;
					ST_STOP2:   step_d = last_frame ? ST_IDLE : ST_START;
					default:    step_d = ST_IDLE;
				endcase
			end
		end
	end

	// Line levels, shifter, counters and the digit source.
	always_comb begin
		shift_d  = shift_q;
		bitcnt_d = bitcnt_q;
		frame_d  = frame_q;
		digit_d  = digit_q;
		clk_d    = clk_q;
		dlow_d   = dlow_q;
		rem_d    = rem_q;
		dot_d    = dot_q;
		done_d   = 1'b0;
		if (step_en) begin
			if (item.op == OP_SHOW) begin
				if (idle) begin
					rem_d    = num_mod;
					dot_d    = item.dot;
					digit_d  = 2'd0;
					frame_d  = FRAME_DATA;
					bitcnt_d = 4'd0;
					shift_d  = CMD_DATA;
				end
			end else begin
				case (step_q)
					ST_START: begin
						dlow_d   = 1'b1;
						bitcnt_d = 4'd0;
					end
					ST_BITLOW: clk_d = 1'b0;
					ST_BITDATA: dlow_d = ~shift_q[0];
					ST_BITHIGH: begin
						clk_d    = 1'b1;
						shift_d  = {1'b0, shift_q[7:1]};
						bitcnt_d = bitcnt_inc;
					end
					ST_ACK0: begin
						clk_d  = 1'b0;
						dlow_d = 1'b0;
					end
					ST_ACK1: clk_d = 1'b1;
					ST_ACK2: begin
						if (!item.line_in) begin
							dlow_d = 1'b1;
						end
					end
					ST_ACK3: begin
						clk_d = 1'b0;
						if (frame_q == FRAME_ADDR) begin
							frame_d  = FRAME_SEG;
							shift_d  = {dot_q, 7'd0} | glyph(digit_val);
							rem_d    = quot;
							bitcnt_d = 4'd0;
						end
					end
					ST_STOP0: dlow_d = 1'b1;
					ST_STOP1: clk_d = 1'b1;
					ST_STOP2: begin
						dlow_d = 1'b0;
						done_d = last_frame;
						if (frame_q == FRAME_DATA) begin
							frame_d = FRAME_ADDR;
							shift_d = CMD_ADDR + {6'd0, ~digit_q};
						end else if (frame_q != FRAME_CTRL) begin
							frame_d = FRAME_CTRL;
							shift_d = CMD_CTRL + {4'd0, brightness};
						end else if (digit_q != LAST_DIGIT) begin
							digit_d = digit_q + 2'd1;
							frame_d = FRAME_DATA;
							shift_d = CMD_DATA;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result of this item, taken from the levels after it.
	always_comb begin
		result.clock_line_high = clk_d;
		result.data_pull_low   = dlow_d;
		result.busy            = (step_d != ST_IDLE);
		result.done            = done_d;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= ST_IDLE;
			shift_q  <= 8'd0;
			bitcnt_q <= 4'd0;
			frame_q  <= FRAME_DATA;
			digit_q  <= 2'd0;
			clk_q    <= 1'b0;
			dlow_q   <= 1'b0;
		end else begin
			step_q   <= step_d;
			shift_q  <= shift_d;
			bitcnt_q <= bitcnt_d;
			frame_q  <= frame_d;
			digit_q  <= digit_d;
			clk_q    <= clk_d;
			dlow_q   <= dlow_d;
		end
	end

	// Stored number and dot flag.
	always_ff @(posedge clk) begin
		rem_q <= rem_d;
		dot_q <= dot_d;
	end

endmodule

// ===== rtl/seven_segment_serial_display_driver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver_core
// Four-digit seven-segment display driver over a two-wire link, one delay
// tick or show request per input transfer, one line-level result per item.
//
// Channel   Direction  Width           Content
// s_*       in         16 + tuser 1    number, dot, data_line_in; tuser = op
// m_*       out        8 + tlast 1     clock_line_high, data_pull_low, busy_res
//                                      in tdata; tlast = update_done
// cfg_*     in         4               brightness register write
//
// One item is taken every cycle while the result side does not stall; its
// result passes through the input register and then the result register
// before it is presented.
// The sequencer state after reset is idle with both lines low-clock, released.
// A stall on m_tready holds the result; the input register then fills and
// s_tready drops only while both registers are full.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_driver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [13:0] number, [14] dot, [15] data_line_in
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] clock_line_high, [1] data_pull_low,
	                               // [2] busy_res, [7:3] zero
	output logic        m_tlast,   // update_done
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_wdata
);
	import ssd_pkg::*;

	logic        valid_s1;
	ssd_item_t   item_s1;
	logic        advance;
	logic        out_valid_q;
	ssd_result_t out_q;
	ssd_result_t result;
	logic [3:0]  brightness_q;

	// The input stage moves on when the result register is free or emptying.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Brightness register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= 4'd0;
		end else if (cfg_wen) begin
			brightness_q <= cfg_wdata;
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op      <= s_tuser;
			item_s1.number  <= s_tdata[13:0];
			item_s1.dot     <= s_tdata[14];
			item_s1.line_in <= s_tdata[15];
		end
	end

	ssd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.item       (item_s1),
		.brightness (brightness_q),
		.result     (result)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.busy, out_q.data_pull_low, out_q.clock_line_high};
	assign m_tlast  = out_q.done;

endmodule

// ===== rtl/ssd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks of the display driver, bound to its top level.
// ----------------------------------------------------------------------------
`include "seven_segment_serial_display_driver_core_macros.svh"

module ssd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// A held result keeps its content until it is taken.
	`SSD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// Input back-pressure only ever comes from a waiting result.
	`SSD_ASSERT_SAME(a_ready, !s_tready, m_tvalid)

	// The transfer that ends an update reports the block idle.
	`SSD_ASSERT_SAME(a_done_idle, m_tvalid && m_tlast, !m_tdata[2])

	// An update ends after a stop: clock high and data released.
	`SSD_ASSERT_SAME(a_done_lines, m_tvalid && m_tlast, m_tdata[0] && !m_tdata[1])

endmodule

bind seven_segment_serial_display_driver_core ssd_checker u_ssd_checker (.*);

// ===== dv/seven_segment_serial_display_driver_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver_core_tb
// Drives ticks and show requests into the display driver and checks the line
// levels of every result against a cycle-free model of the link sequencer.
// Directed items cover idle ticks, out-of-range numbers and ignored shows;
// random traffic then runs whole display updates at several brightness
// settings, with and without random idling on both stream sides.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_driver_core_tb;
	import ssd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 27;
	localparam int SETTLE      = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        s_tuser   = OP_TICK;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_wen   = 1'b0;
	logic [3:0]  cfg_wdata = '0;

	// Model state of the link sequencer.
	logic [3:0]  bright;
	logic [7:0]  seg_bytes [4];
	logic [7:0]  shift_reg;
	logic [3:0]  bit_cnt;
	ssd_step_t   link_step;
	logic [1:0]  frame_idx;
	logic [1:0]  digit_idx;
	logic        clk_high;
	logic        data_low;
	logic [7:0]  glyph_rom [10];

	ssd_result_t expected_levels [$];
	logic [14:0] planned_shows [$];   // {dot, number} for the next accepted shows
	logic        no_idle = 1'b0;
	int          errors = 0;
	int          items_sent = 0;
	int          results_checked = 0;
	int          updates_seen = 0;
	int          cycle_count = 0;

	seven_segment_serial_display_driver_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("seven_segment_serial_display_driver_core test failed");
			$finish;
		end
	end

	// Result side: compare each transfer with the oldest expectation and
	// drive a random stall pattern on m_tready.
	always @(posedge clk) begin : check_levels
		ssd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_levels.size() == 0) begin
				$error("result transfer with no expectation pending");
				errors++;
			end else begin
				want = expected_levels.pop_front();
				results_checked++;
				if (m_tdata[0] !== want.clock_line_high) begin
					$error("clock_line_high: expected %0b, actual %0b",
						want.clock_line_high, m_tdata[0]);
					errors++;
				end
				if (m_tdata[1] !== want.data_pull_low) begin
					$error("data_pull_low: expected %0b, actual %0b",
						want.data_pull_low, m_tdata[1]);
					errors++;
				end
				if (m_tdata[2] !== want.busy) begin
					$error("busy_res: expected %0b, actual %0b", want.busy, m_tdata[2]);
					errors++;
				end
				if (m_tlast !== want.done) begin
					$error("update_done: expected %0b, actual %0b", want.done, m_tlast);
					errors++;
				end
				if (want.done)
					updates_seen++;
			end
		end
		m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// Advance the sequencer model by one input item and give its line levels.
	task automatic predict_line_levels(input ssd_item_t it, output ssd_result_t res);
		logic        finished;
		logic [13:0] val;
		int          k;
		finished = 1'b0;
		if (it.op == OP_SHOW) begin
			// A show only starts an update when the sequencer is idle.
			if (link_step == ST_IDLE) begin
				val = it.number % 14'd10000;
				for (k = 0; k < 4; k++) begin
					seg_bytes[k] = {it.dot, 7'd0} | glyph_rom[val % 14'd10];
					val = val / 14'd10;
				end
				digit_idx = '0;
				frame_idx = FRAME_DATA;
				bit_cnt   = '0;
				shift_reg = CMD_DATA;
				link_step = ST_START;
			end
		end else if (link_step != ST_IDLE) begin
			case (link_step)
				ST_START: begin
					data_low  = 1'b1;
					bit_cnt   = '0;
					link_step = ST_BITLOW;
				end
				ST_BITLOW: begin
					clk_high  = 1'b0;
					link_step = ST_BITDATA;
				end
				ST_BITDATA: begin
					data_low  = ~shift_reg[0];
					link_step = ST_BITHIGH;
				end
				ST_BITHIGH: begin
					clk_high  = 1'b1;
					shift_reg = shift_reg >> 1;
					bit_cnt   = bit_cnt + 4'd1;
					if (bit_cnt >= 4'd8)
						link_step = ST_ACK0;
					else
						link_step = ST_BITLOW;
				end
				ST_ACK0: begin
					clk_high  = 1'b0;
					data_low  = 1'b0;
					link_step = ST_ACK1;
				end
				ST_ACK1: begin
					clk_high  = 1'b1;
					link_step = ST_ACK2;
				end
				ST_ACK2: begin
					// The receiver acknowledges by holding the data line low.
					if (!it.line_in)
						data_low = 1'b1;
					link_step = ST_ACK3;
				end
				ST_ACK3: begin
					clk_high = 1'b0;
					// The address byte is followed by the segment byte in one frame.
					if (frame_idx == FRAME_ADDR) begin
						frame_idx = FRAME_SEG;
						shift_reg = seg_bytes[digit_idx];
						bit_cnt   = '0;
						link_step = ST_BITLOW;
					end else begin
						link_step = ST_STOP0;
					end
				end
				ST_STOP0: begin
					data_low  = 1'b1;
					link_step = ST_STOP1;
				end
				ST_STOP1: begin
					clk_high  = 1'b1;
					link_step = ST_STOP2;
				end
				default: begin
					// End of a frame: load the next command or finish the update.
					data_low = 1'b0;
					if (frame_idx == FRAME_DATA) begin
						frame_idx = FRAME_ADDR;
						shift_reg = CMD_ADDR + {6'd0, 2'd3 - digit_idx};
						link_step = ST_START;
					end else if (frame_idx != FRAME_CTRL) begin
						frame_idx = FRAME_CTRL;
						shift_reg = CMD_CTRL + {4'd0, bright};
						link_step = ST_START;
					end else if (digit_idx == LAST_DIGIT) begin
						link_step = ST_IDLE;
						finished  = 1'b1;
					end else begin
						digit_idx = digit_idx + 2'd1;
						frame_idx = FRAME_DATA;
						shift_reg = CMD_DATA;
						link_step = ST_START;
					end
				end
			endcase
		end
		res.clock_line_high = clk_high;
		res.data_pull_low   = data_low;
		res.busy            = (link_step != ST_IDLE);
		res.done            = finished;
	endtask

	// Send one item with a random gap before it and queue its expected levels.
	task automatic send_item(input logic op, input logic [13:0] num, input logic dot,
		input logic line_in);
		ssd_item_t   it;
		ssd_result_t res;
		it.op      = op;
		it.number  = num;
		it.dot     = dot;
		it.line_in = line_in;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {line_in, dot, num};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		predict_line_levels(it, res);
		expected_levels.push_back(res);
		items_sent++;
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_brightness(input logic [3:0] val);
		wait_drained();
		cfg_wdata <= val;
		cfg_wen   <= 1'b1;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		bright = val;
	endtask

	// Numbers weighted toward the ends of the range and past 9999.
	function automatic logic [13:0] pick_number();
		case ($urandom_range(9))
			0: return 14'd0;
			1: return 14'd9999;
			2: return 14'd10000 + 14'($urandom_range(6383));
			default: return 14'($urandom_range(16383));
		endcase
	endfunction

	// Random traffic: mostly ticks during an update, mostly shows when idle.
	// Ticks while idle and shows while busy do not count as active items.
	task automatic run_link_traffic(input int n_active);
		int          active;
		logic        busy_now;
		logic        op;
		logic [14:0] pick;
		active = 0;
		while (active < n_active) begin
			busy_now = (link_step != ST_IDLE);
			if (busy_now)
				op = ($urandom_range(99) < 2) ? OP_SHOW : OP_TICK;
			else
				op = ($urandom_range(99) < 60) ? OP_SHOW : OP_TICK;
			if (op == OP_SHOW && !busy_now && planned_shows.size() != 0)
				pick = planned_shows.pop_front();
			else
				pick = {($urandom_range(1) == 1), pick_number()};
			send_item(op, pick[13:0], pick[14], ($urandom_range(1) == 1));
			if (busy_now != (op == OP_SHOW))
				active++;
		end
	endtask

	task automatic test_idle_ticks();
		write_brightness(4'($urandom_range(1, 14)));
		send_item(OP_TICK, 14'h3FFF, 1'b1, 1'b1);
		send_item(OP_TICK, 14'd0, 1'b0, 1'b0);
	endtask

	task automatic test_show_requests();
		int k;
		// A number above the range shows its four low digits.
		send_item(OP_SHOW, 14'd16383, 1'b0, 1'b1);
		// Shows during an update are ignored.
		send_item(OP_SHOW, 14'd9999, 1'b1, 1'b0);
		for (k = 0; k < 18; k++)
			send_item(OP_TICK, 14'($urandom_range(16383)), k[0], k[1]);
		send_item(OP_SHOW, 14'd0, 1'b0, 1'b1);
		planned_shows.push_back({1'b1, 14'd9999});
		planned_shows.push_back({1'b0, 14'd0});
	endtask

	task automatic test_full_brightness();
		write_brightness(4'd15);
		run_link_traffic(350);
	endtask

	task automatic test_dark_no_stalls();
		write_brightness(4'd0);
		no_idle = 1'b1;
		run_link_traffic(350);
		no_idle = 1'b0;
	endtask

	task automatic test_random_brightness();
		write_brightness(4'($urandom_range(15)));
		run_link_traffic(350);
	endtask

	initial begin
		glyph_rom = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
		bright    = '0;
		seg_bytes = '{default: 8'h00};
		shift_reg = '0;
		bit_cnt   = '0;
		link_step = ST_IDLE;
		frame_idx = '0;
		digit_idx = '0;
		clk_high  = 1'b0;
		data_low  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_show_requests();
		test_full_brightness();
		test_dark_no_stalls();
		test_random_brightness();
		wait_drained();

		$display("Sent %0d items, checked %0d results, saw %0d finished display updates",
			items_sent, results_checked, updates_seen);
		$display("across brightness 0, 15 and random values, with and without stalls.");
		if (errors == 0)
			$display("seven_segment_serial_display_driver_core test passed");
		else
			$display("seven_segment_serial_display_driver_core test failed");
		$finish;
	end

endmodule
